FILE: hdl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, op codes and the step command for the circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

   localparam int CoordBits = 12;
   localparam int PixBits   = CoordBits + 1;
   localparam int DecBits   = CoordBits + 2;
   localparam int RadBits   = CoordBits - 1;
   localparam int QueueDepth = 4;
   localparam int PtrBits    = $clog2(QueueDepth);

   localparam logic OpStart = 1'b0;
   localparam logic OpStep  = 1'b1;

   typedef struct packed {
      logic                        done;
      logic signed [CoordBits-1:0] cx;
      logic signed [CoordBits-1:0] cy;
      logic signed [CoordBits-1:0] x;
      logic signed [CoordBits-1:0] y;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

FILE: hdl/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasterizer with eight-way symmetry.
// ----------------------------------------------------------------------------
// A start transaction (op 0) loads centre and radius and gives no result. A
// step transaction (op 1) gives eight pixels, the eighth marked last, or one
// done result once the octant is finished. The front accepts a transaction
// every cycle while its 4-entry command queue has room; the single result
// port then drains one pixel per cycle while the receiver pops. With the back
// end idle, an accepted step is first written into the queue and then its
// first pixel is registered into the output register.
module midpoint_circle_rasterizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_op,
   input  logic signed [mcr_pkg::CoordBits-1:0] req_center_x,
   input  logic signed [mcr_pkg::CoordBits-1:0] req_center_y,
   input  logic        [mcr_pkg::RadBits-1:0]   req_radius,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [mcr_pkg::PixBits-1:0]   rsp_pixel_x,
   output logic signed [mcr_pkg::PixBits-1:0]   rsp_pixel_y,
   output logic                                 rsp_last,
   output logic                                 rsp_done_res
);

   logic              accept, q_push, q_pop;
   mcr_pkg::cmd_type  q_cmd;
   mcr_pkg::head_type q_head;

   assign accept = push && !full;

   mcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_op),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   mcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (full),
      .head     (q_head)
   );

   mcr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .pixel_x  (rsp_pixel_x),
      .pixel_y  (rsp_pixel_y),
      .last     (rsp_last),
      .done_res (rsp_done_res)
   );

endmodule

FILE: hdl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Takes start and step transactions, keeps centre, offsets and decision value,
// and queues one command per step.
// ----------------------------------------------------------------------------
module mcr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 op,
   input  logic signed [mcr_pkg::CoordBits-1:0] center_x,
   input  logic signed [mcr_pkg::CoordBits-1:0] center_y,
   input  logic        [mcr_pkg::RadBits-1:0]   radius,
   output logic                                 q_push,
   output mcr_pkg::cmd_type                     q_cmd
);

   logic signed [mcr_pkg::CoordBits-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [mcr_pkg::CoordBits-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [mcr_pkg::DecBits-1:0]   dec_ff, dec_in;
   logic signed [mcr_pkg::DecBits-1:0]   x_ext, y_ext;
   logic                                 finished;

   assign finished = x_ff > y_ff;
   assign x_ext    = mcr_pkg::DecBits'(x_ff);
   assign y_ext    = mcr_pkg::DecBits'(y_ff);

   assign q_push      = accept && (op == mcr_pkg::OpStep);
   assign q_cmd.done  = finished;
   assign q_cmd.cx    = cx_ff;
   assign q_cmd.cy    = cy_ff;
   assign q_cmd.x     = x_ff;
   assign q_cmd.y     = y_ff;

   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      dec_in = dec_ff;
      if (accept && op == mcr_pkg::OpStart) begin
         cx_in  = center_x;
         cy_in  = center_y;
         x_in   = '0;
         y_in   = $signed(mcr_pkg::CoordBits'(radius));
         dec_in = mcr_pkg::DecBits'(1) - $signed(mcr_pkg::DecBits'(radius));
      end else if (q_push && !finished) begin
         if (dec_ff < 0) begin
            dec_in = dec_ff + (x_ext <<< 1) + mcr_pkg::DecBits'(3);
         end else begin
            dec_in = dec_ff + ((x_ext - y_ext) <<< 1) + mcr_pkg::DecBits'(5);
            y_in   = y_ff - mcr_pkg::CoordBits'(1);
         end
         x_in = x_ff + mcr_pkg::CoordBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         x_ff   <= '0;
         y_ff   <= '0;
         dec_ff <= '0;
      end else begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         dec_ff <= dec_in;
      end
   end

endmodule

FILE: hdl/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Short command FIFO between the front and the pixel generator.
// ----------------------------------------------------------------------------
module mcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcr_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output logic              full,
   output mcr_pkg::head_type head
);

   mcr_pkg::cmd_type                mem [mcr_pkg::QueueDepth];
   logic [mcr_pkg::PtrBits-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [mcr_pkg::PtrBits:0]       count_ff, count_in;
   logic                            do_push, do_pop;

   assign full       = count_ff == (mcr_pkg::PtrBits+1)'(mcr_pkg::QueueDepth);
   assign head.valid = count_ff != '0;
   assign head.cmd   = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (mcr_pkg::PtrBits+1)'(mcr_pkg::QueueDepth))
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

FILE: hdl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands each command into eight symmetric pixels, or one done result,
// one per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module mcr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  mcr_pkg::head_type                   head,
   output logic                                q_pop,
   input  logic                                pop,
   output logic                                empty,
   output logic signed [mcr_pkg::PixBits-1:0]  pixel_x,
   output logic signed [mcr_pkg::PixBits-1:0]  pixel_y,
   output logic                                last,
   output logic                                done_res
);

   logic                                busy_ff, busy_in;
   logic [2:0]                          idx_ff, idx_in;
   mcr_pkg::cmd_type                    cmd_ff, cmd_in;
   logic                                ov_ff, ov_in;
   logic signed [mcr_pkg::PixBits-1:0]  px_ff, px_in, py_ff, py_in;
   logic                                last_ff, last_in, done_ff, done_in;
   logic                                advance;
   mcr_pkg::cmd_type                    src;
   logic [2:0]                          k;
   logic signed [mcr_pkg::PixBits-1:0]  cx, cy, a, b;

   assign advance = !ov_ff || pop;
   assign src     = busy_ff ? cmd_ff : head.cmd;
   assign k       = busy_ff ? idx_ff : 3'd0;
   assign q_pop   = advance && !busy_ff && head.valid;

   always_comb begin
      cx = mcr_pkg::PixBits'(src.cx);
      cy = mcr_pkg::PixBits'(src.cy);
      a  = k[2] ? mcr_pkg::PixBits'(src.y) : mcr_pkg::PixBits'(src.x);
      b  = k[2] ? mcr_pkg::PixBits'(src.x) : mcr_pkg::PixBits'(src.y);
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cmd_in  = cmd_ff;
      ov_in   = ov_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (advance) begin
         ov_in   = busy_ff || head.valid;
         px_in   = k[0] ? cx - a : cx + a;
         py_in   = k[1] ? cy - b : cy + b;
         last_in = k == 3'd7;
         done_in = 1'b0;
         if (busy_ff) begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd7) busy_in = 1'b0;
         end else if (head.valid) begin
            if (head.cmd.done) begin
               px_in   = '0;
               py_in   = '0;
               last_in = 1'b1;
               done_in = 1'b1;
            end else begin
               busy_in = 1'b1;
               idx_in  = 3'd1;
               cmd_in  = head.cmd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd1;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         ov_ff   <= ov_in;
      end
      cmd_ff  <= cmd_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign empty    = !ov_ff;
   assign pixel_x  = px_ff;
   assign pixel_y  = py_ff;
   assign last     = last_ff;
   assign done_res = done_ff;

   a_busy_idx: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff != 3'd0)
      else $error("pixel index wrapped while busy");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_pop)
      else $error("command taken while expanding another");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && done_ff) |-> (last_ff && px_ff == '0 && py_ff == '0))
      else $error("done result malformed");

endmodule

FILE: tb/sv/tb_midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer
// Self-checking testbench for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// Start and step transactions are queued by an initial block and fed to the
// block by a falling-edge driver with random idle bursts. A cycle-free model
// of the octant walk predicts every pixel; a rising-edge monitor compares
// each popped pixel against the oldest prediction. The receiver idles in
// random bursts, holds off once for a long stretch to fill the block, and the
// sender waits for a full drain at least once.
module tb_midpoint_circle_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   CoordBits = mcr_pkg::CoordBits;
   localparam int   PixBits   = mcr_pkg::PixBits;
   localparam int   DecBits   = mcr_pkg::DecBits;
   localparam int   RadBits   = mcr_pkg::RadBits;
   localparam logic OpStart   = mcr_pkg::OpStart;
   localparam logic OpStep    = mcr_pkg::OpStep;

   localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
   localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
   localparam logic [RadBits-1:0]          RadMax   = '1;

   typedef struct {
      logic                        op;
      logic signed [CoordBits-1:0] cx;
      logic signed [CoordBits-1:0] cy;
      logic [RadBits-1:0]          rad;
      bit                          drain_first;
   } circle_cmd_type;

   typedef struct {
      logic signed [PixBits-1:0] px;
      logic signed [PixBits-1:0] py;
      logic                      last;
      logic                      done;
   } pixel_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        push = 1'b0;
   logic                        full;
   logic                        req_op = OpStart;
   logic signed [CoordBits-1:0] req_center_x = '0;
   logic signed [CoordBits-1:0] req_center_y = '0;
   logic [RadBits-1:0]          req_radius = '0;
   logic                        empty;
   logic                        pop = 1'b0;
   logic signed [PixBits-1:0]   rsp_pixel_x;
   logic signed [PixBits-1:0]   rsp_pixel_y;
   logic                        rsp_last;
   logic                        rsp_done_res;

   circle_cmd_type cmd_backlog[$];
   pixel_type      pixels_due[$];
   circle_cmd_type cur_cmd;
   bit          sent = 1'b0;
   bit          calm = 1'b0;
   int          fail_count = 0;
   int          pixels_seen = 0;
   int          tx_gap = 0, tx_run = 0, rx_gap = 0, rx_run = 0;
   int          hold_left = 0;
   bit          hold_used = 1'b0;

   // rasterizer state as predicted
   logic signed [CoordBits-1:0] ctr_x = '0, ctr_y = '0, off_x = '0, off_y = '0;
   logic signed [DecBits-1:0]   dec_val = '0;

   midpoint_circle_rasterizer i_dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_op       (req_op),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .empty        (empty),
      .pop          (pop),
      .rsp_pixel_x  (rsp_pixel_x),
      .rsp_pixel_y  (rsp_pixel_y),
      .rsp_last     (rsp_last),
      .rsp_done_res (rsp_done_res)
   );

   always #5 clock = ~clock;

   task automatic trace_octant(input circle_cmd_type c);
      logic signed [CoordBits-1:0] x, y;
      logic signed [PixBits-1:0]   xs[8];
      logic signed [PixBits-1:0]   ys[8];
      pixel_type                   p;
      if (c.op == OpStart) begin
         ctr_x   = c.cx;
         ctr_y   = c.cy;
         off_x   = '0;
         off_y   = {1'b0, c.rad};
         dec_val = DecBits'(1 - int'(c.rad));
      end else if (off_x > off_y) begin
         p.px   = '0;
         p.py   = '0;
         p.last = 1'b1;
         p.done = 1'b1;
         pixels_due.push_back(p);
      end else begin
         x = off_x;
         y = off_y;
         xs[0] = PixBits'(ctr_x) + PixBits'(x);  ys[0] = PixBits'(ctr_y) + PixBits'(y);
         xs[1] = PixBits'(ctr_x) - PixBits'(x);  ys[1] = PixBits'(ctr_y) + PixBits'(y);
         xs[2] = PixBits'(ctr_x) + PixBits'(x);  ys[2] = PixBits'(ctr_y) - PixBits'(y);
         xs[3] = PixBits'(ctr_x) - PixBits'(x);  ys[3] = PixBits'(ctr_y) - PixBits'(y);
         xs[4] = PixBits'(ctr_x) + PixBits'(y);  ys[4] = PixBits'(ctr_y) + PixBits'(x);
         xs[5] = PixBits'(ctr_x) - PixBits'(y);  ys[5] = PixBits'(ctr_y) + PixBits'(x);
         xs[6] = PixBits'(ctr_x) + PixBits'(y);  ys[6] = PixBits'(ctr_y) - PixBits'(x);
         xs[7] = PixBits'(ctr_x) - PixBits'(y);  ys[7] = PixBits'(ctr_y) - PixBits'(x);
         for (int k = 0; k < 8; k++) begin
            p.px   = xs[k];
            p.py   = ys[k];
            p.last = (k == 7);
            p.done = 1'b0;
            pixels_due.push_back(p);
         end
         if (dec_val < 0) begin
            dec_val = DecBits'(int'(dec_val) + 2 * int'(x) + 3);
         end else begin
            dec_val = DecBits'(int'(dec_val) + 2 * (int'(x) - int'(y)) + 5);
            off_y   = CoordBits'(int'(y) - 1);
         end
         off_x = CoordBits'(int'(x) + 1);
      end
   endtask

   task automatic add_cmd(input logic op, input logic signed [CoordBits-1:0] cx,
                          input logic signed [CoordBits-1:0] cy,
                          input logic [RadBits-1:0] rad, input bit drain);
      circle_cmd_type c;
      c.op          = op;
      c.cx          = cx;
      c.cy          = cy;
      c.rad         = rad;
      c.drain_first = drain;
      cmd_backlog.push_back(c);
   endtask

   // centre and radius are don't-care on a step, so they are randomized
   task automatic add_step();
      add_cmd(OpStep, CoordBits'($urandom), CoordBits'($urandom), RadBits'($urandom), 1'b0);
   endtask

   function automatic bit take_break(inout int gap, inout int run);
      if (gap > 0) begin
         gap--;
         return 1'b1;
      end
      if (run > 0) begin
         run--;
         return 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17) - 1;
         return 1'b1;
      end
      run = $urandom_range(0, 40);
      return 1'b0;
   endfunction

   // driver
   always @(negedge clock) begin
      calm <= (cmd_backlog.size() < 40);
      if (reset) begin
         push <= 1'b0;
      end else if (!push || sent) begin
         sent = 1'b0;
         if (cmd_backlog.size() == 0 ||
             (cmd_backlog[0].drain_first && pixels_due.size() != 0) ||
             (!calm && take_break(tx_gap, tx_run))) begin
            push <= 1'b0;
         end else begin
            cur_cmd = cmd_backlog.pop_front();
            push         <= 1'b1;
            req_op       <= cur_cmd.op;
            req_center_x <= cur_cmd.cx;
            req_center_y <= cur_cmd.cy;
            req_radius   <= cur_cmd.rad;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!hold_used && pixels_seen >= 200) begin
         hold_used = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= calm || !take_break(rx_gap, rx_run);
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (pop && !empty) begin
            pixels_seen++;
            if (pixels_due.size() == 0) begin
               fail_count++;
               $display("%0t: expected no transaction, actual pixel (%0d, %0d) last %0b done %0b",
                        $time, rsp_pixel_x, rsp_pixel_y, rsp_last, rsp_done_res);
            end else begin
               want = pixels_due.pop_front();
               if (rsp_pixel_x !== want.px) begin
                  fail_count++;
                  $display("%0t: pixel_x expected %0d, actual %0d",
                           $time, want.px, rsp_pixel_x);
               end
               if (rsp_pixel_y !== want.py) begin
                  fail_count++;
                  $display("%0t: pixel_y expected %0d, actual %0d",
                           $time, want.py, rsp_pixel_y);
               end
               if (rsp_last !== want.last) begin
                  fail_count++;
                  $display("%0t: last expected %0b, actual %0b", $time, want.last, rsp_last);
               end
               if (rsp_done_res !== want.done) begin
                  fail_count++;
                  $display("%0t: done_res expected %0b, actual %0b",
                           $time, want.done, rsp_done_res);
               end
            end
         end
         if (push && !full) begin
            sent = 1'b1;
            trace_octant(cur_cmd);
         end
      end
   end

   initial begin
      int  kind, n, r;
      bit  drain;

      // steps from the reset state, then repeated done
      add_step();
      add_step();
      add_step();
      // radius zero at corner centres
      add_cmd(OpStart, CoordMax, CoordMin, '0, 1'b0);
      add_step();
      add_step();
      // largest radius at extreme centres
      add_cmd(OpStart, CoordMin, CoordMax, RadMax, 1'b0);
      repeat (3) add_step();
      add_cmd(OpStart, CoordMax, CoordMax, RadMax, 1'b0);
      repeat (2) add_step();
      add_cmd(OpStart, CoordMin, CoordMin, RadBits'(1), 1'b0);
      repeat (3) add_step();
      add_cmd(OpStart, '0, '0, RadBits'(3), 1'b0);
      repeat (5) add_step();

      drain = 1'b1;
      while (cmd_backlog.size() < 270) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 48) : $urandom_range(0, 20);
            add_cmd(OpStart, CoordBits'($urandom), CoordBits'($urandom), RadBits'(r), drain);
            n = (r * 3) / 4 + 2 + $urandom_range(0, 2);
            repeat (n) add_step();
         end else if (kind < 88) begin
            add_cmd(OpStart, CoordBits'($urandom), CoordBits'($urandom), RadBits'($urandom),
                    drain);
            n = $urandom_range(0, 6);
            repeat (n) add_step();
         end else begin
            n = $urandom_range(1, 4);
            repeat (n)
               add_cmd(1'($urandom_range(0, 1)), CoordBits'($urandom), CoordBits'($urandom),
                       RadBits'($urandom), drain);
         end
         drain = ($urandom_range(0, 19) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || push) @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
